FILE: rtl/sha224_256_hash_engine_core_defines.svh
// assertion macros for the hash engine
`ifndef SHA224_256_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA224_256_HASH_ENGINE_CORE_DEFINES_SVH

// implication checked every clock, quiet while in reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sha_pkg.sv
package sha_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned Rounds  = 64;
    localparam int unsigned RoundW  = 6;
    localparam logic [31:0] PadWord = 32'h8000_0000;
    localparam int unsigned DefaultMode = 0;

    // controller to datapath commands
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_ROUND,
        OP_FINISH,
        OP_RELOAD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] word;
        logic [RoundW-1:0] round;
        logic        load_vars;
        logic        mode;
    } t_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic mode, input logic [2:0] idx);
        logic [31:0] h;
        unique case ({mode, idx})
            4'd0:  h = 32'h6a09e667; 4'd1:  h = 32'hbb67ae85;
            4'd2:  h = 32'h3c6ef372; 4'd3:  h = 32'ha54ff53a;
            4'd4:  h = 32'h510e527f; 4'd5:  h = 32'h9b05688c;
            4'd6:  h = 32'h1f83d9ab; 4'd7:  h = 32'h5be0cd19;
            4'd8:  h = 32'hc1059ed8; 4'd9:  h = 32'h367cd507;
            4'd10: h = 32'h3070dd17; 4'd11: h = 32'hf70e5939;
            4'd12: h = 32'hffc00b31; 4'd13: h = 32'h68581511;
            4'd14: h = 32'h64f98fa7; default: h = 32'hbefa4fa4;
        endcase
        return h;
    endfunction

endpackage

FILE: rtl/sha224_256_hash_engine_core.sv
// sha-224/256 hash engine with built-in padding
// input: drive i_message_word, i_byte_count, i_final_word with start; a word
// is taken on a clock edge where start is high and busy is low
// a word that completes a block is followed by the 64 rounds and the chain add, with
// busy high until they are done; other words only fill the block; the sustained word rate is set by the
// single shared round unit
// a final word adds padding (one or two blocks) and then the
// digest: 8 words (7 in sha-224 mode) on o_digest_word, one per cycle, each
// marked by o_digest_valid for exactly one cycle; the receiver cannot stall
// mode: i_cfg_valid/o_cfg_ready write i_cfg_data while idle; this aborts any
// message and loads the initial hash of the new mode
// reset: synchronous, active low; after release the S_RESET state loads the sha-256
// initial values, then the block is idle
`include "sha224_256_hash_engine_core_defines.svh"

module sha224_256_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_final_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_digest_valid,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_of_digest
);

    sha_pkg::t_cmd cmd;
    logic [31:0]   hash [8];

    sha_control u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_message_word   (i_message_word),
        .i_byte_count     (i_byte_count),
        .i_final_word     (i_final_word),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_hash           (hash),
        .o_busy           (busy),
        .o_cfg_ready      (o_cfg_ready),
        .o_cmd            (cmd),
        .o_digest_valid   (o_digest_valid),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_of_digest (o_last_of_digest)
    );

    sha_datapath u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .o_hash (hash)
    );

    `SHA_ASSERT_IMP(a_last_has_strobe, i_clk, i_rst_n, o_last_of_digest, o_digest_valid,
        "last flag without digest strobe")
    `SHA_ASSERT_IMP(a_no_ready_when_busy, i_clk, i_rst_n, busy, !o_cfg_ready,
        "config ready while busy")
    `SHA_ASSERT_NEXT(a_last_ends_digest, i_clk, i_rst_n, o_last_of_digest, !o_digest_valid,
        "digest strobe after last word")

endmodule

FILE: rtl/sha_datapath.sv
module sha_datapath (
    input  logic              i_clk,
    input  sha_pkg::t_cmd     i_cmd,
    output logic [31:0]       o_hash [8]
);

    logic [31:0] r_hash [8];
    logic [31:0] r_var  [8];
    logic [31:0] r_win  [16];

    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] x15, x2, x7, x16, s0, s1, w_new, w, big0, big1, chv, maj, t1, t2;
    logic [3:0]  t_idx;

    assign t_idx = i_cmd.round[3:0];

    always_comb begin
        // at load, round uses the chain values directly
        a = i_cmd.load_vars ? r_hash[0] : r_var[0];
        b = i_cmd.load_vars ? r_hash[1] : r_var[1];
        c = i_cmd.load_vars ? r_hash[2] : r_var[2];
        d = i_cmd.load_vars ? r_hash[3] : r_var[3];
        e = i_cmd.load_vars ? r_hash[4] : r_var[4];
        f = i_cmd.load_vars ? r_hash[5] : r_var[5];
        g = i_cmd.load_vars ? r_hash[6] : r_var[6];
        h = i_cmd.load_vars ? r_hash[7] : r_var[7];
        x15   = r_win[t_idx + 4'd1];
        x2    = r_win[t_idx + 4'd14];
        x7    = r_win[t_idx + 4'd9];
        x16   = r_win[t_idx];
        s0    = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
        s1    = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
        w_new = x16 + s0 + x7 + s1;
        w     = (i_cmd.round[5:4] != 2'd0) ? w_new : x16;
        big1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        chv   = (e & f) ^ (~e & g);
        t1    = h + big1 + chv + sha_pkg::round_k(i_cmd.round) + w;
        big0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj   = (a & b) ^ (a & c) ^ (b & c);
        t2    = big0 + maj;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            sha_pkg::OP_PUSH: begin
                r_win[t_idx] <= i_cmd.word;
            end
            sha_pkg::OP_ROUND: begin
                r_win[t_idx] <= w;
                r_var[0] <= t1 + t2;
                r_var[1] <= a;
                r_var[2] <= b;
                r_var[3] <= c;
                r_var[4] <= d + t1;
                r_var[5] <= e;
                r_var[6] <= f;
                r_var[7] <= g;
            end
            sha_pkg::OP_FINISH: begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_var[i];
                end
            end
            sha_pkg::OP_RELOAD: begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= sha_pkg::init_hash(i_cmd.mode, 3'(i));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_hash = r_hash;

endmodule

FILE: rtl/sha_control.sv
module sha_control (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_message_word,
    input  logic [2:0]        i_byte_count,
    input  logic              i_final_word,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  logic [31:0]       i_hash [8],
    output logic              o_busy,
    output logic              o_cfg_ready,
    output sha_pkg::t_cmd     o_cmd,
    output logic              o_digest_valid,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_of_digest
);

    localparam logic [2:0] S_RESET  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ROUND  = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_PAD    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]  r_state, n_state;
    logic        r_mode, n_mode;
    logic [3:0]  r_wib, n_wib;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_round, n_round;
    logic        r_final, n_final;
    logic        r_pend80, n_pend80;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_ov, n_ov;
    logic [31:0] r_od, n_od;
    logic [2:0]  r_oi, n_oi;
    logic        r_ol, n_ol;
    logic        r_done_len, n_done_len;
    logic        r_len_ok, n_len_ok;
    logic [2:0]  cnt;
    logic [31:0] mask, padw;
    logic        accept;

    assign o_busy       = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE) && !i_start;
    assign accept       = i_start && !o_busy;
    assign cnt          = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign mask         = ~(32'hffff_ffff >> {cnt[1:0], 3'b000});
    assign padw         = (i_message_word & mask) | (sha_pkg::PadWord >> {cnt[1:0], 3'b000});

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_wib    = r_wib;
        n_len    = r_len;
        n_round  = r_round;
        n_final  = r_final;
        n_pend80 = r_pend80;
        n_len_ok = r_len_ok;
        n_oidx   = r_oidx;
        n_ov     = 1'b0;
        n_od     = r_od;
        n_oi     = r_oi;
        n_ol     = 1'b0;
        o_cmd    = '{op: sha_pkg::OP_NONE, word: '0, round: r_round,
                     load_vars: 1'b0, mode: r_mode};
        unique case (r_state)
            S_RESET: begin
                o_cmd.op = sha_pkg::OP_RELOAD;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid && o_cfg_ready) begin
                    n_mode     = i_cfg_data;
                    n_wib      = '0;
                    n_len      = '0;
                    o_cmd.op   = sha_pkg::OP_RELOAD;
                    o_cmd.mode = i_cfg_data;
                end else if (accept) begin
                    o_cmd.op    = sha_pkg::OP_PUSH;
                    o_cmd.round = {2'b00, r_wib};
                    n_wib       = r_wib + 4'd1;
                    n_final     = i_final_word;
                    n_pend80    = 1'b0;
                    if (!i_final_word) begin
                        o_cmd.word = i_message_word;
                        n_len      = r_len + 64'd32;
                    end else begin
                        n_len = r_len + {58'd0, cnt, 3'b000};
                        // length fits only if the pad word lands at slot 13 or below
                        n_len_ok = (cnt == 3'd4) ? (r_wib < 4'd13) : (r_wib < 4'd14);
                        if (cnt == 3'd4) begin
                            o_cmd.word = i_message_word;
                            n_pend80   = 1'b1;
                        end else begin
                            o_cmd.word = padw;
                        end
                    end
                    if (r_wib == 4'd15) begin
                        n_state = S_ROUND;
                        n_round = '0;
                    end else if (i_final_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // pad byte first if still pending, then zeros, length in the last two slots when it fits
                o_cmd.op    = sha_pkg::OP_PUSH;
                o_cmd.round = {2'b00, r_wib};
                n_wib       = r_wib + 4'd1;
                if (r_pend80) begin
                    o_cmd.word = sha_pkg::PadWord;
                    n_pend80   = 1'b0;
                end else if (r_len_ok && r_wib == 4'd14) begin
                    o_cmd.word = r_len[63:32];
                end else if (r_len_ok && r_wib == 4'd15) begin
                    o_cmd.word = r_len[31:0];
                end else begin
                    o_cmd.word = '0;
                end
                if (r_wib == 4'd15) begin
                    n_state = S_ROUND;
                    n_round = '0;
                end
            end
            S_ROUND: begin
                o_cmd.op        = sha_pkg::OP_ROUND;
                o_cmd.load_vars = (r_round == '0);
                n_round         = r_round + 6'd1;
                if (r_round == 6'(sha_pkg::Rounds - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.op = sha_pkg::OP_FINISH;
                n_round  = '0;
                n_len_ok = 1'b1;
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (r_done_len) begin
                    n_state = S_OUT;
                end else begin
                    // pad byte or length still to come in a further block
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                n_ov   = 1'b1;
                n_od   = i_hash[r_oidx];
                n_oi   = r_oidx;
                n_ol   = (r_oidx == (r_mode ? 3'd6 : 3'd7));
                n_oidx = r_oidx + 3'd1;
                if (n_ol) begin
                    n_state  = S_RESET;
                    n_oidx   = '0;
                    n_wib    = '0;
                    n_len    = '0;
                    n_final  = 1'b0;
                end
            end
            default: begin
                n_state = S_RESET;
            end
        endcase
    end

    // set when the block just pushed held the length words
    always_comb begin
        n_done_len = r_done_len;
        if (o_cmd.op == sha_pkg::OP_PUSH && o_cmd.round[3:0] == 4'd15) begin
            n_done_len = r_final && (r_state == S_PAD) && !r_pend80 && r_len_ok;
        end
        if (r_state == S_OUT || r_state == S_RESET) begin
            n_done_len = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RESET;
            r_mode     <= 1'(sha_pkg::DefaultMode);
            r_wib      <= '0;
            r_len      <= '0;
            r_round    <= '0;
            r_final    <= 1'b0;
            r_pend80   <= 1'b0;
            r_len_ok   <= 1'b0;
            r_oidx     <= '0;
            r_ov       <= 1'b0;
            r_ol       <= 1'b0;
            r_done_len <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_wib      <= n_wib;
            r_len      <= n_len;
            r_round    <= n_round;
            r_final    <= n_final;
            r_pend80   <= n_pend80;
            r_len_ok   <= n_len_ok;
            r_oidx     <= n_oidx;
            r_ov       <= n_ov;
            r_ol       <= n_ol;
            r_done_len <= n_done_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_oi <= n_oi;
    end

    assign o_digest_valid   = r_ov;
    assign o_digest_word    = r_od;
    assign o_word_index     = r_oi;
    assign o_last_of_digest = r_ol;

endmodule
